### src/plct_pkg.sv
// Shared types and constants for the point light cull table.
// No dependencies; imported by plct_radius and point_light_cull_table_unit.
package plct_pkg;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_UPDATE = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;
    localparam logic [1:0] FUNC_RECALC = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_MATCH   = 3'd1;
    localparam logic [2:0] ST_NOMATCH = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BADIDX  = 3'd4;

    localparam logic [5:0]  RESULT_CAP   = 6'd32;
    localparam logic [31:0] RADIUS_MAX   = 32'hFFFF_FFFF;
    localparam logic [15:0] THRESH_RESET = 16'd1280;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] coef_c;
        logic [31:0] coef_l;
        logic [31:0] coef_q;
    } t_light;

endpackage

### src/plct_radius.sv
// Radius of influence unit: solves q*r^2 + l*r + (c - 1/thr) = 0 for r.
// Shared restoring divider, split multiplier and digit-by-digit square root.
// Depends on plct_pkg.
module plct_radius (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_coef_c,
    input  logic [31:0] i_coef_l,
    input  logic [31:0] i_coef_q,
    input  logic [15:0] i_thr,
    output logic        o_done,
    output logic [31:0] o_radius
);
    import plct_pkg::*;

    typedef enum logic [10:0] {
        R_IDLE = 11'b00000000001,
        R_RDIV = 11'b00000000010,
        R_MAG  = 11'b00000000100,
        R_PLO  = 11'b00000001000,
        R_PHI  = 11'b00000010000,
        R_SUM  = 11'b00000100000,
        R_DISC = 11'b00001000000,
        R_SQRT = 11'b00010000000,
        R_NUM  = 11'b00100000000,
        R_QDIV = 11'b01000000000,
        R_FIN  = 11'b10000000000
    } t_rstate;

    localparam logic [5:0] DIV_LAST  = 6'd55;
    localparam logic [5:0] SQRT_LAST = 6'd53;

    t_rstate       r_state;
    logic [31:0]   r_c, r_l, r_q;
    logic [55:0]   r_dvd;
    logic [33:0]   r_rem;
    logic [33:0]   r_dsr;
    logic [5:0]    r_cnt;
    logic          r_cc_pos;
    logic [40:0]   r_mag;
    logic [63:0]   r_ll;
    logic [63:0]   r_plo;
    logic [40:0]   r_phi;
    logic [74:0]   r_t;
    logic [107:0]  r_rad;
    logic [55:0]   r_srem;
    logic [53:0]   r_root;
    logic [31:0]   r_res;

    logic [34:0]   div_rt;
    logic          div_ge;
    logic [31:0]   quo_sat;
    logic [57:0]   sq_r2;
    logic [57:0]   sq_trial;
    logic          sq_ge;
    logic [41:0]   cc;
    logic [75:0]   ll_ext;
    logic [75:0]   t_ext;
    logic [72:0]   psum;
    logic [53:0]   lsh;

    always_comb begin
        div_rt   = {r_rem, r_dvd[55]};
        div_ge   = div_rt >= {1'b0, r_dsr};
        // Quotient after the last divide step, saturated to 32 bits.
        quo_sat  = (r_dvd[54:31] != '0) ? RADIUS_MAX : {r_dvd[30:0], div_ge};
        sq_r2    = {r_srem, r_rad[107:106]};
        sq_trial = {2'b00, r_root, 2'b01};
        sq_ge    = sq_r2 >= sq_trial;
        cc       = {10'b0, r_c} - {1'b0, r_dvd[40:0]};
        ll_ext   = {12'b0, r_ll};
        t_ext    = {1'b0, r_t};
        psum     = {r_phi, 32'b0} + {9'b0, r_plo};
        lsh      = {6'b0, r_l, 16'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
        end else begin
            unique case (r_state) inside
                R_IDLE: begin
                    if (i_start) begin
                        r_c   <= i_coef_c;
                        r_l   <= i_coef_l;
                        r_q   <= i_coef_q;
                        r_dvd <= {15'b0, 1'b1, 40'b0};
                        r_rem <= '0;
                        r_dsr <= {18'b0, i_thr};
                        r_cnt <= '0;
                        if (i_coef_q == '0 || i_thr == '0) begin
                            r_res   <= RADIUS_MAX;
                            r_state <= R_FIN;
                        end else begin
                            r_state <= R_RDIV;
                        end
                    end
                end
                R_RDIV, R_QDIV: begin
                    r_rem <= div_ge ? 34'(div_rt - {1'b0, r_dsr}) : div_rt[33:0];
                    r_dvd <= {r_dvd[54:0], div_ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= (r_state == R_RDIV) ? R_MAG : R_FIN;
                        if (r_state == R_QDIV) begin
                            r_res <= quo_sat;
                        end
                    end
                end
                R_MAG: begin
                    // Recip sits in the low bits of the divider register here.
                    r_cc_pos <= !cc[41] && (cc != '0);
                    r_mag    <= cc[41] ? 41'(-cc) : cc[40:0];
                    r_ll     <= 64'(r_l) * 64'(r_l);
                    r_state  <= R_PLO;
                end
                R_PLO: begin
                    r_plo   <= 64'(r_q) * 64'(r_mag[31:0]);
                    r_state <= R_PHI;
                end
                R_PHI: begin
                    r_phi   <= 41'(r_q) * 41'(r_mag[40:32]);
                    r_state <= R_SUM;
                end
                R_SUM: begin
                    r_t     <= {psum, 2'b00};
                    r_state <= R_DISC;
                end
                R_DISC: begin
                    r_srem <= '0;
                    r_root <= '0;
                    r_cnt  <= '0;
                    if (r_cc_pos && t_ext > ll_ext) begin
                        r_res   <= RADIUS_MAX;
                        r_state <= R_FIN;
                    end else begin
                        r_rad   <= {(r_cc_pos ? ll_ext - t_ext : ll_ext + t_ext), 32'b0};
                        r_state <= R_SQRT;
                    end
                end
                R_SQRT: begin
                    r_srem  <= sq_ge ? 56'(sq_r2 - sq_trial) : sq_r2[55:0];
                    r_root  <= {r_root[52:0], sq_ge};
                    r_rad   <= {r_rad[105:0], 2'b00};
                    r_cnt   <= r_cnt + 6'd1;
                    if (r_cnt == SQRT_LAST) begin
                        r_state <= R_NUM;
                    end
                end
                R_NUM: begin
                    r_dvd <= {2'b00, r_root - lsh};
                    r_rem <= '0;
                    r_dsr <= {1'b0, r_q, 1'b0};
                    r_cnt <= '0;
                    if (r_root <= lsh) begin
                        r_res   <= '0;
                        r_state <= R_FIN;
                    end else begin
                        r_state <= R_QDIV;
                    end
                end
                R_FIN: begin
                    r_state <= R_IDLE;
                end
                default: begin
                    r_state <= R_IDLE;
                end
            endcase
        end
    end

    assign o_done   = (r_state == R_FIN);
    assign o_radius = r_res;

endmodule

### src/point_light_cull_table_unit.sv
// Point light table with sphere-of-influence culling, top level.
// Depends on plct_pkg and plct_radius.
//
//   channel   handshake                     beat
//   command   start / busy                  func, index, light, entity fields
//   config    i_cfg_valid / o_cfg_ready     light threshold (16 bits)
//   result    o_result_valid (strobe)       status, match_index, last
//
// Add and update hold busy while the radius unit runs its two 56-step divides and
// 54-step square root; a zero quadratic term or threshold skips them. Recompute
// runs the radius unit once per stored light. A query streams stored lights
// through read, square, sum and compare stages, then flushes; earlier matches
// strobe while busy. Each final result strobes in the cycle busy drops; rejected
// commands answer the next cycle without raising busy. Reset is synchronous and
// active low and empties the table. The receiver cannot stall results.
module point_light_cull_table_unit #(
    parameter int MAX_LIGHTS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_func,
    input  logic [4:0]           i_light_index,
    input  logic signed [31:0]   i_light_x,
    input  logic signed [31:0]   i_light_y,
    input  logic signed [31:0]   i_light_z,
    input  logic [31:0]          i_atten_constant,
    input  logic [31:0]          i_atten_linear,
    input  logic [31:0]          i_atten_quadratic,
    input  logic signed [31:0]   i_entity_x,
    input  logic signed [31:0]   i_entity_y,
    input  logic signed [31:0]   i_entity_z,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [15:0]          i_cfg_data,
    output logic                 o_result_valid,
    output logic [2:0]           o_status,
    output logic [4:0]           o_match_index,
    output logic                 o_last
);
    import plct_pkg::*;

    localparam int IW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int CW = $clog2(MAX_LIGHTS + 1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_CALC     = 7'b0000010,
        S_REC_RD   = 7'b0000100,
        S_REC_GO   = 7'b0001000,
        S_REC_WAIT = 7'b0010000,
        S_WALK     = 7'b0100000,
        S_FLUSH    = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_addr, n_addr;
    logic [IW-1:0]   r_slot, n_slot;
    logic            r_issue, n_issue;
    logic            r_pend_v, n_pend_v;
    logic [IW-1:0]   r_pend_idx, n_pend_idx;
    logic [5:0]      r_nmatch, n_nmatch;
    logic [15:0]     r_thr;
    logic [31:0]     r_ent_x, r_ent_y, r_ent_z;
    logic            r_out_v, n_out_v;
    logic [2:0]      r_status, n_status;
    logic [4:0]      r_midx, n_midx;
    logic            r_last, n_last;

    // Radius unit.
    logic        rad_start, rad_done;
    logic [31:0] rad_radius;
    logic [31:0] rad_c, rad_l, rad_q_in;

    // Record and radius memories with registered read ports.
    t_light          rec_mem [MAX_LIGHTS];
    logic [31:0]     rad_mem [MAX_LIGHTS];
    t_light          rec_q;
    logic [31:0]     rad_q;
    logic            rec_we, rad_we;
    logic [IW-1:0]   rec_waddr, rad_waddr;
    t_light          rec_wdata;

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        rec_q <= rec_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (rad_we) begin
            rad_mem[rad_waddr] <= rad_radius;
        end
        rad_q <= rad_mem[r_addr];
    end

    plct_radius u_radius (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (rad_start),
        .i_coef_c (rad_c),
        .i_coef_l (rad_l),
        .i_coef_q (rad_q_in),
        .i_thr    (r_thr),
        .o_done   (rad_done),
        .o_radius (rad_radius)
    );

    // Index arithmetic at parameter-derived widths.
    logic            accept;
    logic            tbl_full, idx_bad, at_end;
    logic [CW+4:0]   idx_cmp;
    logic [CW+4:0]   cnt_cmp;
    logic [IW+4:0]   idx_wide;
    logic [IW-1:0]   idx_addr;
    logic [CW-1:0]   cnt_m1;
    logic [CW+IW-1:0] addr_cmp, last_cmp;
    logic [IW+4:0]   slot_wide, pend_wide;

    always_comb begin
        accept    = start && !busy;
        tbl_full  = r_count >= CW'(MAX_LIGHTS);
        idx_cmp   = {{CW{1'b0}}, i_light_index};
        cnt_cmp   = {5'b0, r_count};
        idx_bad   = idx_cmp >= cnt_cmp;
        idx_wide  = {{IW{1'b0}}, i_light_index};
        idx_addr  = idx_wide[IW-1:0];
        cnt_m1    = r_count - 1'b1;
        addr_cmp  = {{CW{1'b0}}, r_addr};
        last_cmp  = {{IW{1'b0}}, cnt_m1};
        at_end    = addr_cmp == last_cmp;
        slot_wide = {5'b0, r_slot};
        pend_wide = {5'b0, r_pend_idx};
    end

    // Query pipeline: memory read, squares, sum, compare.
    logic            r_p1_v, r_p1_last;
    logic [IW-1:0]   r_p1_idx;
    logic            r_p2_v, r_p2_last;
    logic [IW-1:0]   r_p2_idx;
    logic [65:0]     r_sqx, r_sqy, r_sqz;
    logic [63:0]     r_rr;
    logic            r_p3_v, r_p3_last;
    logic [IW-1:0]   r_p3_idx;
    logic [67:0]     r_sum;
    logic [63:0]     r_rr3;
    logic [32:0]     dx, dy, dz, mx, my, mz;
    logic            walking, p3_match;

    always_comb begin
        walking  = (r_state == S_WALK);
        dx       = {rec_q.pos_x[31], rec_q.pos_x} - {r_ent_x[31], r_ent_x};
        dy       = {rec_q.pos_y[31], rec_q.pos_y} - {r_ent_y[31], r_ent_y};
        dz       = {rec_q.pos_z[31], rec_q.pos_z} - {r_ent_z[31], r_ent_z};
        mx       = dx[32] ? -dx : dx;
        my       = dy[32] ? -dy : dy;
        mz       = dz[32] ? -dz : dz;
        // A sum beyond 64 bits can never be under a 64-bit squared radius.
        p3_match = r_sum <= {4'b0, r_rr3};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
        end else begin
            r_p1_v <= walking && r_issue;
            r_p2_v <= walking && r_p1_v;
            r_p3_v <= walking && r_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_last <= at_end;
        r_p1_idx  <= r_addr;
        r_p2_last <= r_p1_last;
        r_p2_idx  <= r_p1_idx;
        r_sqx     <= 66'(mx) * 66'(mx);
        r_sqy     <= 66'(my) * 66'(my);
        r_sqz     <= 66'(mz) * 66'(mz);
        r_rr      <= 64'(rad_q) * 64'(rad_q);
        r_p3_last <= r_p2_last;
        r_p3_idx  <= r_p2_idx;
        r_sum     <= {2'b0, r_sqx} + {2'b0, r_sqy} + {2'b0, r_sqz};
        r_rr3     <= r_rr;
    end

    // Control.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_addr     = r_addr;
        n_slot     = r_slot;
        n_issue    = r_issue;
        n_pend_v   = r_pend_v;
        n_pend_idx = r_pend_idx;
        n_nmatch   = r_nmatch;
        n_out_v    = 1'b0;
        n_status   = r_status;
        n_midx     = r_midx;
        n_last     = r_last;
        rec_we     = 1'b0;
        rec_waddr  = idx_addr;
        rad_we     = 1'b0;
        rad_waddr  = (r_state == S_CALC) ? r_slot : r_addr;
        rad_start  = 1'b0;
        rec_wdata  = '{pos_x: i_light_x, pos_y: i_light_y, pos_z: i_light_z,
                       coef_c: i_atten_constant, coef_l: i_atten_linear,
                       coef_q: i_atten_quadratic};
        rad_c      = i_atten_constant;
        rad_l      = i_atten_linear;
        rad_q_in   = i_atten_quadratic;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_func)
                        FUNC_ADD: begin
                            if (tbl_full) begin
                                n_out_v  = 1'b1;
                                n_status = ST_FULL;
                                n_midx   = '0;
                                n_last   = 1'b1;
                            end else begin
                                rec_we    = 1'b1;
                                rec_waddr = r_count[IW-1:0];
                                rad_start = 1'b1;
                                n_slot    = r_count[IW-1:0];
                                n_count   = r_count + 1'b1;
                                n_state   = S_CALC;
                            end
                        end
                        FUNC_UPDATE: begin
                            if (idx_bad) begin
                                n_out_v  = 1'b1;
                                n_status = ST_BADIDX;
                                n_midx   = i_light_index;
                                n_last   = 1'b1;
                            end else begin
                                rec_we    = 1'b1;
                                rad_start = 1'b1;
                                n_slot    = idx_addr;
                                n_state   = S_CALC;
                            end
                        end
                        FUNC_RECALC: begin
                            n_addr = '0;
                            if (r_count == '0) begin
                                n_out_v  = 1'b1;
                                n_status = ST_OK;
                                n_midx   = '0;
                                n_last   = 1'b1;
                            end else begin
                                n_state = S_REC_RD;
                            end
                        end
                        default: begin
                            n_addr   = '0;
                            n_pend_v = 1'b0;
                            n_nmatch = '0;
                            if (r_count == '0) begin
                                n_out_v  = 1'b1;
                                n_status = ST_NOMATCH;
                                n_midx   = '0;
                                n_last   = 1'b1;
                            end else begin
                                n_issue = 1'b1;
                                n_state = S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_CALC: begin
                if (rad_done) begin
                    rad_we   = 1'b1;
                    n_out_v  = 1'b1;
                    n_status = ST_OK;
                    n_midx   = slot_wide[4:0];
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_REC_RD: begin
                n_state = S_REC_GO;
            end
            S_REC_GO: begin
                rad_start = 1'b1;
                rad_c     = rec_q.coef_c;
                rad_l     = rec_q.coef_l;
                rad_q_in  = rec_q.coef_q;
                n_state   = S_REC_WAIT;
            end
            S_REC_WAIT: begin
                if (rad_done) begin
                    rad_we = 1'b1;
                    if (at_end) begin
                        n_out_v  = 1'b1;
                        n_status = ST_OK;
                        n_midx   = '0;
                        n_last   = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_addr  = r_addr + 1'b1;
                        n_state = S_REC_RD;
                    end
                end
            end
            S_WALK: begin
                if (r_issue) begin
                    if (at_end) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                // Each match is held back until the next one arrives so the final one can carry last.
                if (r_p3_v) begin
                    if (p3_match) begin
                        if (r_pend_v) begin
                            n_out_v  = 1'b1;
                            n_status = ST_MATCH;
                            n_midx   = pend_wide[4:0];
                            n_last   = 1'b0;
                        end
                        n_pend_v   = 1'b1;
                        n_pend_idx = r_p3_idx;
                        n_nmatch   = r_nmatch + 6'd1;
                        if (r_nmatch == RESULT_CAP - 6'd1) begin
                            n_issue = 1'b0;
                            n_state = S_FLUSH;
                        end
                    end
                    if (r_p3_last) begin
                        n_issue = 1'b0;
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                n_out_v = 1'b1;
                n_last  = 1'b1;
                if (r_pend_v) begin
                    n_status = ST_MATCH;
                    n_midx   = pend_wide[4:0];
                end else begin
                    n_status = ST_NOMATCH;
                    n_midx   = '0;
                end
                n_pend_v = 1'b0;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_issue  <= 1'b0;
            r_pend_v <= 1'b0;
            r_nmatch <= '0;
            r_out_v  <= 1'b0;
            r_thr    <= THRESH_RESET;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_issue  <= n_issue;
            r_pend_v <= n_pend_v;
            r_nmatch <= n_nmatch;
            r_out_v  <= n_out_v;
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_slot     <= n_slot;
        r_pend_idx <= n_pend_idx;
        r_status   <= n_status;
        r_midx     <= n_midx;
        r_last     <= n_last;
        if (accept && i_func == FUNC_QUERY) begin
            r_ent_x <= i_entity_x;
            r_ent_y <= i_entity_y;
            r_ent_z <= i_entity_z;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_out_v;
    assign o_status       = r_status;
    assign o_match_index  = r_midx;
    assign o_last         = r_last;

endmodule
